// File: hdl/hiz_pkg.sv
// Shared types and constants for the hierarchical-Z occlusion test engine.
// Holds the opcode, state, datapath command and status types.
// No dependencies.
package hiz_pkg;

   localparam int CW = 7;        // coordinate and side width
   localparam int DW = 25;       // signed depth code width, -1 is empty
   localparam int SPAN_L2 = 16;  // spans above this test on level 2
   localparam int SPAN_L1 = 8;   // spans above this test on level 1

   typedef enum logic [1:0] {
      OP_LOAD       = 2'd0,
      OP_TEST       = 2'd1,
      OP_WRITE      = 2'd2,
      OP_TEST_WRITE = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_T_EMPTY, S_T_RD, S_T_CHK,
      S_W_INIT, S_W_EMPTY, S_W_RD, S_W_WR, S_LOADWR, S_FULL, S_UP,
      S_R0, S_R1, S_R2, S_R3, S_RWR, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      INIT_NONE, INIT_TEST, INIT_WRITE, INIT_LOAD, INIT_FULL, INIT_UP
   } init_type;

   typedef enum logic [1:0] {
      WR_CLEAR, WR_LOAD, WR_FAR, WR_ACC
   } wsel_type;

   typedef struct packed {
      logic       capture;
      logic       cfg_we;
      init_type   init;
      logic       advance;
      logic       rd_src;
      logic [1:0] rd_sub;
      logic       acc_en;
      logic       acc_first;
      logic       wr_en;
      wsel_type   wr_sel;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   last;
      logic   fail;
      logic   has_up;
      logic   load_ok;
      logic   clr_last;
   } stat_type;

endpackage

// File: hdl/hiz_datapath.sv
// Datapath of the hierarchical-Z engine: depth pyramid memories, scan
// counters, address arithmetic and compare logic.
// Depends on hiz_pkg.
module hiz_datapath #(
   parameter int MAX_RES = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hiz_pkg::cmd_type         cmd,
   output hiz_pkg::stat_type        stat,
   input  logic [1:0]               req_opcode,
   input  logic [5:0]               req_rect_min_x,
   input  logic [5:0]               req_rect_min_y,
   input  logic [5:0]               req_rect_max_x,
   input  logic [5:0]               req_rect_max_y,
   input  logic signed [24:0]       req_near_value,
   input  logic [23:0]              req_far_value,
   input  logic [6:0]               csr_base_resolution,
   output logic [1:0]               level_used
);
   import hiz_pkg::*;

   localparam int D0 = MAX_RES * MAX_RES;
   localparam int D1 = (MAX_RES / 2) * (MAX_RES / 2);
   localparam int D2 = (MAX_RES / 4) * (MAX_RES / 4);
   localparam int A0 = $clog2(D0);
   localparam int A1 = $clog2(D1);
   localparam int A2 = (D2 > 1) ? $clog2(D2) : 1;

   logic signed [DW-1:0] mem0 [D0];
   logic signed [DW-1:0] mem1 [D1];
   logic signed [DW-1:0] mem2 [D2];
   logic signed [DW-1:0] rd0_ff, rd1_ff, rd2_ff, rdata, acc_ff, wdata;

   logic [6:0]      res_ff;
   logic [A0-1:0]   clr_ff;
   op_type          op_ff;
   logic [5:0]      x0_ff, y0_ff, x1_ff, y1_ff;
   logic signed [DW-1:0] near_ff;
   logic [23:0]     far_ff;
   logic [CW-1:0]   bx0_ff, bx1_ff, by0_ff, by1_ff, cx_ff, cy_ff;
   logic [1:0]      lvl_ff, tl_ff, rl_ff;

   logic [CW-1:0] side0, side1, side2;
   logic signed [7:0] span_w, span_h, span;
   logic [1:0]    tlvl, rl, nl;
   logic [CW-1:0] tlim, tx0, ty0, tx1, ty1, tsx1, tsy1;
   logic [CW-1:0] wx1, wy1, lim0, nlim;
   logic [CW-1:0] ux0, ux1, uy0, uy1;
   logic [CW-1:0] rside, wside, rx, ry;
   logic [CW:0]   sx, sy;
   logic [A0-1:0] raddr, waddr;
   logic          clearing;
   logic signed [DW-1:0] far_ext;

   function automatic logic [CW-1:0] side_sel(input logic [1:0] l,
                                              input logic [CW-1:0] s0,
                                              input logic [CW-1:0] s1,
                                              input logic [CW-1:0] s2);
      case (l)
         2'd0:    side_sel = s0;
         2'd1:    side_sel = s1;
         default: side_sel = s2;
      endcase
   endfunction

   function automatic logic [CW-1:0] umin(input logic [CW-1:0] a,
                                          input logic [CW-1:0] b);
      umin = (a < b) ? a : b;
   endfunction

   // level sides
   always_comb begin
      if (res_ff == '0) begin
         side0 = CW'(1);
      end else if (int'(res_ff) > MAX_RES) begin
         side0 = CW'(MAX_RES);
      end else begin
         side0 = res_ff;
      end
      side1 = side0 >> 1;
      side2 = side1 >> 1;
      lim0  = side0 - CW'(1);
   end

   // test and write setup: level by span, scaled and clamped bounds
   always_comb begin
      span_w = $signed({2'b00, x1_ff}) - $signed({2'b00, x0_ff}) + 8'sd1;
      span_h = $signed({2'b00, y1_ff}) - $signed({2'b00, y0_ff}) + 8'sd1;
      span   = (span_w > span_h) ? span_w : span_h;
      if (span > 8'(SPAN_L2) && side1 > CW'(1)) begin
         tlvl = 2'd2;
      end else if (span > 8'(SPAN_L1) && side0 > CW'(1)) begin
         tlvl = 2'd1;
      end else begin
         tlvl = 2'd0;
      end
      tlim = side_sel(tlvl, side0, side1, side2) - CW'(1);
      tx0  = {1'b0, x0_ff} >> tlvl;
      ty0  = {1'b0, y0_ff} >> tlvl;
      tsx1 = {1'b0, x1_ff} >> tlvl;
      tsy1 = {1'b0, y1_ff} >> tlvl;
      tx1  = umin(tsx1, tlim);
      ty1  = umin(tsy1, tlim);
      wx1  = umin({1'b0, x1_ff}, lim0);
      wy1  = umin({1'b0, y1_ff}, lim0);
      // region one level up
      nl   = lvl_ff + 2'd1;
      nlim = side_sel(nl, side0, side1, side2) - CW'(1);
      ux0  = umin(bx0_ff >> 1, nlim);
      ux1  = umin(bx1_ff >> 1, nlim);
      uy0  = umin(by0_ff >> 1, nlim);
      uy1  = umin(by1_ff >> 1, nlim);
   end

   // read and write addresses
   always_comb begin
      rl    = cmd.rd_src ? (lvl_ff - 2'd1) : lvl_ff;
      rside = side_sel(rl, side0, side1, side2);
      sx    = {cx_ff, 1'b0} + {CW'(0), cmd.rd_sub[0]};
      sy    = {cy_ff, 1'b0} + {CW'(0), cmd.rd_sub[1]};
      if (cmd.rd_src) begin
         rx = (sx > {1'b0, rside - CW'(1)}) ? (rside - CW'(1)) : sx[CW-1:0];
         ry = (sy > {1'b0, rside - CW'(1)}) ? (rside - CW'(1)) : sy[CW-1:0];
      end else begin
         rx = cx_ff;
         ry = cy_ff;
      end
      raddr    = A0'({CW'(0), ry} * {CW'(0), rside} + {CW'(0), rx});
      wside    = side_sel(lvl_ff, side0, side1, side2);
      clearing = (cmd.wr_sel == WR_CLEAR);
      if (clearing) begin
         waddr = clr_ff;
      end else begin
         waddr = A0'({CW'(0), cy_ff} * {CW'(0), wside} + {CW'(0), cx_ff});
      end
   end

   // read data and write data
   always_comb begin
      case (rl_ff)
         2'd0:    rdata = rd0_ff;
         2'd1:    rdata = rd1_ff;
         default: rdata = rd2_ff;
      endcase
      far_ext = $signed({1'b0, far_ff});
      case (cmd.wr_sel)
         WR_CLEAR: wdata = -25'sd1;
         WR_LOAD:  wdata = (near_ff < 0) ? -25'sd1 : near_ff;
         WR_FAR:   wdata = (rdata > far_ext) ? rdata : far_ext;
         WR_ACC:   wdata = (rdata > acc_ff) ? rdata : acc_ff;
         default:  wdata = -25'sd1;
      endcase
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (cmd.wr_en && (clearing || lvl_ff == 2'd0) && int'(waddr) < D0) begin
         mem0[waddr[A0-1:0]] <= wdata;
      end
      rd0_ff <= mem0[raddr[A0-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && (clearing || lvl_ff == 2'd1) && int'(waddr) < D1) begin
         mem1[waddr[A1-1:0]] <= wdata;
      end
      rd1_ff <= mem1[raddr[A1-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && (clearing || lvl_ff == 2'd2) && int'(waddr) < D2) begin
         mem2[waddr[A2-1:0]] <= wdata;
      end
      rd2_ff <= mem2[raddr[A2-1:0]];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= 7'd64;
         clr_ff <= '0;
      end else begin
         if (cmd.cfg_we) begin
            res_ff <= csr_base_resolution;
         end
         if (cmd.wr_en && clearing) begin
            clr_ff <= clr_ff + A0'(1);
         end
      end
   end

   // request capture, scan counters, accumulator
   always_ff @(posedge clock) begin
      rl_ff <= rl;
      if (cmd.capture) begin
         op_ff   <= op_type'(req_opcode);
         x0_ff   <= req_rect_min_x;
         y0_ff   <= req_rect_min_y;
         x1_ff   <= req_rect_max_x;
         y1_ff   <= req_rect_max_y;
         near_ff <= req_near_value;
         far_ff  <= req_far_value;
         tl_ff   <= 2'd0;
      end
      case (cmd.init)
         INIT_TEST: begin
            bx0_ff <= tx0; bx1_ff <= tx1; by0_ff <= ty0; by1_ff <= ty1;
            cx_ff  <= tx0; cy_ff  <= ty0;
            lvl_ff <= tlvl; tl_ff <= tlvl;
         end
         INIT_WRITE: begin
            bx0_ff <= {1'b0, x0_ff}; bx1_ff <= wx1;
            by0_ff <= {1'b0, y0_ff}; by1_ff <= wy1;
            cx_ff  <= {1'b0, x0_ff}; cy_ff  <= {1'b0, y0_ff};
            lvl_ff <= 2'd0;
         end
         INIT_LOAD: begin
            bx0_ff <= {1'b0, x0_ff}; bx1_ff <= {1'b0, x0_ff};
            by0_ff <= {1'b0, y0_ff}; by1_ff <= {1'b0, y0_ff};
            cx_ff  <= {1'b0, x0_ff}; cy_ff  <= {1'b0, y0_ff};
            lvl_ff <= 2'd0;
         end
         INIT_FULL: begin
            bx0_ff <= '0; bx1_ff <= lim0; by0_ff <= '0; by1_ff <= lim0;
            cx_ff  <= '0; cy_ff  <= '0;
            lvl_ff <= 2'd0;
         end
         INIT_UP: begin
            bx0_ff <= ux0; bx1_ff <= ux1; by0_ff <= uy0; by1_ff <= uy1;
            cx_ff  <= ux0; cy_ff  <= uy0;
            lvl_ff <= nl;
         end
         default: begin
            if (cmd.advance) begin
               if (cx_ff == bx1_ff) begin
                  cx_ff <= bx0_ff;
                  cy_ff <= cy_ff + CW'(1);
               end else begin
                  cx_ff <= cx_ff + CW'(1);
               end
            end
         end
      endcase
      if (cmd.acc_en) begin
         if (cmd.acc_first) begin
            acc_ff <= rdata;
         end else begin
            acc_ff <= (rdata > acc_ff) ? rdata : acc_ff;
         end
      end
   end

   always_comb begin
      stat.op       = op_ff;
      stat.empty    = (bx0_ff > bx1_ff) || (by0_ff > by1_ff);
      stat.last     = (cx_ff == bx1_ff) && (cy_ff == by1_ff);
      stat.fail     = (rdata < 0) || (near_ff <= rdata);
      stat.has_up   = (lvl_ff == 2'd0) ? (side0 > CW'(1)) :
                      (lvl_ff == 2'd1) ? (side1 > CW'(1)) : 1'b0;
      stat.load_ok  = ({1'b0, x0_ff} < side0) && ({1'b0, y0_ff} < side0);
      stat.clr_last = (int'(clr_ff) == D0 - 1);
   end

   assign level_used = tl_ff;

endmodule

// File: hdl/hiz_ctrl.sv
// Controller of the hierarchical-Z engine: sequences clear, test, write,
// load and pyramid update, and drives the datapath by command.
// Depends on hiz_pkg.
module hiz_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   input  logic              csr_valid,
   input  hiz_pkg::stat_type stat,
   output hiz_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              csr_ready,
   output logic              rsp_done,
   output logic              rsp_occluded,
   output logic              rsp_written
);
   import hiz_pkg::*;

   state_type state_ff, state_in;
   logic occ_ff, occ_in, wr_ff, wr_in, cfg_ff, cfg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         occ_ff   <= 1'b0;
         wr_ff    <= 1'b0;
         cfg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         wr_ff    <= wr_in;
         cfg_ff   <= cfg_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      occ_in   = occ_ff;
      wr_in    = wr_ff;
      cfg_in   = cfg_ff;
      case (state_ff)
         S_CLEAR: if (stat.clr_last) state_in = S_IDLE;
         S_IDLE: begin
            if (req_start) begin
               state_in = S_DISPATCH;
               occ_in   = 1'b0;
               wr_in    = 1'b0;
               cfg_in   = 1'b0;
            end else if (csr_valid) begin
               state_in = S_FULL;
               cfg_in   = 1'b1;
            end
         end
         S_DISPATCH: begin
            case (stat.op)
               OP_LOAD:  state_in = stat.load_ok ? S_LOADWR : S_DONE;
               OP_WRITE: begin
                  state_in = S_W_EMPTY;
                  wr_in    = 1'b1;
               end
               default:  state_in = S_T_EMPTY;
            endcase
         end
         S_T_EMPTY: begin
            if (stat.empty) begin
               occ_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_T_RD;
            end
         end
         S_T_RD: state_in = S_T_CHK;
         S_T_CHK: begin
            if (stat.fail) begin
               state_in = (stat.op == OP_TEST_WRITE) ? S_W_INIT : S_DONE;
            end else if (stat.last) begin
               occ_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_T_RD;
            end
         end
         S_W_INIT: begin
            state_in = S_W_EMPTY;
            wr_in    = 1'b1;
         end
         S_W_EMPTY: state_in = stat.empty ? S_DONE : S_W_RD;
         S_W_RD:    state_in = S_W_WR;
         S_W_WR:    state_in = stat.last ? S_UP : S_W_RD;
         S_LOADWR:  state_in = S_UP;
         S_FULL:    state_in = S_UP;
         S_UP: begin
            if (stat.has_up) begin
               state_in = S_R0;
            end else begin
               state_in = cfg_ff ? S_IDLE : S_DONE;
            end
         end
         S_R0:   state_in = S_R1;
         S_R1:   state_in = S_R2;
         S_R2:   state_in = S_R3;
         S_R3:   state_in = S_RWR;
         S_RWR:  state_in = stat.last ? S_UP : S_R0;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '{capture: 1'b0, cfg_we: 1'b0, init: INIT_NONE, advance: 1'b0,
              rd_src: 1'b0, rd_sub: 2'd0, acc_en: 1'b0, acc_first: 1'b0,
              wr_en: 1'b0, wr_sel: WR_LOAD};
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_CLEAR;
         end
         S_IDLE: begin
            cmd.capture = req_start;
            cmd.cfg_we  = csr_valid && !req_start;
         end
         S_DISPATCH: begin
            case (stat.op)
               OP_LOAD:  cmd.init = stat.load_ok ? INIT_LOAD : INIT_NONE;
               OP_WRITE: cmd.init = INIT_WRITE;
               default:  cmd.init = INIT_TEST;
            endcase
         end
         S_T_CHK:  cmd.advance = !stat.fail && !stat.last;
         S_W_INIT: cmd.init = INIT_WRITE;
         S_W_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_FAR;
            cmd.advance = !stat.last;
         end
         S_LOADWR: cmd.wr_en = 1'b1;
         S_FULL:   cmd.init = INIT_FULL;
         S_UP:     cmd.init = stat.has_up ? INIT_UP : INIT_NONE;
         S_R0: begin
            cmd.rd_src = 1'b1;
            cmd.rd_sub = 2'd0;
         end
         S_R1: begin
            cmd.rd_src    = 1'b1;
            cmd.rd_sub    = 2'd1;
            cmd.acc_en    = 1'b1;
            cmd.acc_first = 1'b1;
         end
         S_R2: begin
            cmd.rd_src = 1'b1;
            cmd.rd_sub = 2'd2;
            cmd.acc_en = 1'b1;
         end
         S_R3: begin
            cmd.rd_src = 1'b1;
            cmd.rd_sub = 2'd3;
            cmd.acc_en = 1'b1;
         end
         S_RWR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_ACC;
            cmd.advance = !stat.last;
         end
         default: ;
      endcase
   end

   assign busy         = (state_ff != S_IDLE);
   assign csr_ready    = (state_ff == S_IDLE) && !req_start;
   assign rsp_done     = (state_ff == S_DONE);
   assign rsp_occluded = occ_ff;
   assign rsp_written  = wr_ff;

endmodule

// File: hdl/hiz_occlusion_test_engine.sv
// Top level of the hierarchical-Z occlusion test engine.
// Instantiates hiz_ctrl and hiz_datapath; depends on hiz_pkg.
//
// Usage:
//  - Request channel: drive req_* and raise req_start; the transfer happens at
//    a rising edge with req_start high and busy low. busy stays high until
//    the result has been shown.
//  - Result channel: rsp_done pulses for one cycle with rsp_occluded,
//    rsp_level_used and rsp_written. The receiver cannot stall it; sample it
//    in that cycle.
//  - Config channel: csr_valid/csr_ready write base_resolution while idle.
//    The write is followed by a rebuild of the upper levels, busy meanwhile.
//  - Sequencing: a test visits texels, stopping at the first failing texel;
//    a write visits each base texel; a load or write then updates each upper
//    level. One item at a time, set by one read port per level.
//  - Reset: synchronous; afterwards the engine sweeps the base level
//    (MAX_RES*MAX_RES addresses, 4096 by default) writing empty into every
//    level, busy high, then resolution is 64.
module hiz_occlusion_test_engine #(
   parameter int MAX_RES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [5:0]         req_rect_min_x,
   input  logic [5:0]         req_rect_min_y,
   input  logic [5:0]         req_rect_max_x,
   input  logic [5:0]         req_rect_max_y,
   input  logic signed [24:0] req_near_value,
   input  logic [23:0]        req_far_value,
   output logic               rsp_done,
   output logic               rsp_occluded,
   output logic [1:0]         rsp_level_used,
   output logic               rsp_written,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_base_resolution
);
   import hiz_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing: clear sweep, scans and pyramid update
   hiz_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_start    (req_start),
      .csr_valid    (csr_valid),
      .stat         (stat),
      .cmd          (cmd),
      .busy         (busy),
      .csr_ready    (csr_ready),
      .rsp_done     (rsp_done),
      .rsp_occluded (rsp_occluded),
      .rsp_written  (rsp_written)
   );

   // pyramid storage and arithmetic
   hiz_datapath #(.MAX_RES(MAX_RES)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_opcode          (req_opcode),
      .req_rect_min_x      (req_rect_min_x),
      .req_rect_min_y      (req_rect_min_y),
      .req_rect_max_x      (req_rect_max_x),
      .req_rect_max_y      (req_rect_max_y),
      .req_near_value      (req_near_value),
      .req_far_value       (req_far_value),
      .csr_base_resolution (csr_base_resolution),
      .level_used          (rsp_level_used)
   );

endmodule

// File: hdl/hiz_checker.sv
// Port-level checks for the hierarchical-Z engine, bound to the top level.
// Depends on hiz_occlusion_test_engine ports only.
module hiz_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_start,
   input logic       busy,
   input logic       rsp_done,
   input logic       rsp_occluded,
   input logic [1:0] rsp_level_used,
   input logic       rsp_written,
   input logic       csr_valid,
   input logic       csr_ready
);

   // accepted request keeps the engine busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_start && !busy |=> busy) else $error("busy not raised after transfer");

   // result pulse lasts one cycle
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_done |=> !rsp_done) else $error("result strobe longer than one cycle");

   // occluded results never write
   a_occ_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_done && rsp_occluded |-> !rsp_written) else $error("occluded but written");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_done |-> rsp_level_used != 2'd3) else $error("bad level");

   // config write starts a rebuild
   a_cfg_busy: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> busy) else $error("no rebuild after config");

endmodule

bind hiz_occlusion_test_engine hiz_checker u_checker (.*);
